/* rtl/sha256_pkg.sv */
// SHA-256 package: round constants, initial hash values and the sigma functions.
// Used by the streaming hasher in rtl/sha256_stream_hasher.sv; depends on nothing.
package sha256_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ROUNDS  = 64;
  localparam int unsigned SCHED_N = 16;
  localparam int unsigned CHAIN_N = 8;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] h_init(input logic [2:0] idx);
    logic [31:0] val;
    case (idx)
      3'd0:    val = 32'h6a09e667;
      3'd1:    val = 32'hbb67ae85;
      3'd2:    val = 32'h3c6ef372;
      3'd3:    val = 32'ha54ff53a;
      3'd4:    val = 32'h510e527f;
      3'd5:    val = 32'h9b05688c;
      3'd6:    val = 32'h1f83d9ab;
      default: val = 32'h5be0cd19;
    endcase
    return val;
  endfunction

  function automatic logic [31:0] k_round(input logic [5:0] idx);
    logic [31:0] val;
    case (idx)
      6'd0:  val = 32'h428a2f98;  6'd1:  val = 32'h71374491;
      6'd2:  val = 32'hb5c0fbcf;  6'd3:  val = 32'he9b5dba5;
      6'd4:  val = 32'h3956c25b;  6'd5:  val = 32'h59f111f1;
      6'd6:  val = 32'h923f82a4;  6'd7:  val = 32'hab1c5ed5;
      6'd8:  val = 32'hd807aa98;  6'd9:  val = 32'h12835b01;
      6'd10: val = 32'h243185be;  6'd11: val = 32'h550c7dc3;
      6'd12: val = 32'h72be5d74;  6'd13: val = 32'h80deb1fe;
      6'd14: val = 32'h9bdc06a7;  6'd15: val = 32'hc19bf174;
      6'd16: val = 32'he49b69c1;  6'd17: val = 32'hefbe4786;
      6'd18: val = 32'h0fc19dc6;  6'd19: val = 32'h240ca1cc;
      6'd20: val = 32'h2de92c6f;  6'd21: val = 32'h4a7484aa;
      6'd22: val = 32'h5cb0a9dc;  6'd23: val = 32'h76f988da;
      6'd24: val = 32'h983e5152;  6'd25: val = 32'ha831c66d;
      6'd26: val = 32'hb00327c8;  6'd27: val = 32'hbf597fc7;
      6'd28: val = 32'hc6e00bf3;  6'd29: val = 32'hd5a79147;
      6'd30: val = 32'h06ca6351;  6'd31: val = 32'h14292967;
      6'd32: val = 32'h27b70a85;  6'd33: val = 32'h2e1b2138;
      6'd34: val = 32'h4d2c6dfc;  6'd35: val = 32'h53380d13;
      6'd36: val = 32'h650a7354;  6'd37: val = 32'h766a0abb;
      6'd38: val = 32'h81c2c92e;  6'd39: val = 32'h92722c85;
      6'd40: val = 32'ha2bfe8a1;  6'd41: val = 32'ha81a664b;
      6'd42: val = 32'hc24b8b70;  6'd43: val = 32'hc76c51a3;
      6'd44: val = 32'hd192e819;  6'd45: val = 32'hd6990624;
      6'd46: val = 32'hf40e3585;  6'd47: val = 32'h106aa070;
      6'd48: val = 32'h19a4c116;  6'd49: val = 32'h1e376c08;
      6'd50: val = 32'h2748774c;  6'd51: val = 32'h34b0bcb5;
      6'd52: val = 32'h391c0cb3;  6'd53: val = 32'h4ed8aa4a;
      6'd54: val = 32'h5b9cca4f;  6'd55: val = 32'h682e6ff3;
      6'd56: val = 32'h748f82ee;  6'd57: val = 32'h78a5636f;
      6'd58: val = 32'h84c87814;  6'd59: val = 32'h8cc70208;
      6'd60: val = 32'h90befffa;  6'd61: val = 32'ha4506ceb;
      6'd62: val = 32'hbef9a3f7;  default: val = 32'hc67178f2;
    endcase
    return val;
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

/* rtl/sha256_stream_hasher.sv */
// Streaming SHA-256 hasher: byte buffer, padding sequencer and one shared round unit.
// Depends on rtl/sha256_pkg.sv for constants and the sigma functions.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, opcode, message_byte  | request in
//  out     | out_valid, out_ready, digest_word,        | result out
//          | word_index, last_word                     |
//
// An absorb request that completes a 64-byte block runs the rounds through the single
// round unit (S_COMP) and then one chaining add (S_ADD); other absorbs only shift their byte in.
// A finish request shifts the remaining pad and length bytes one per cycle, runs one
// or two compressions, then offers eight digest words, one per accepted output cycle.
// The input is not ready while padding, compressing or emitting the digest.
// Reset (rst, synchronous) loads the initial hash values and clears fill and length.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [7:0]  message_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_ADD,
    S_OUT
  } state_t;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  state_t      state;
  logic [5:0]  fill;
  logic [60:0] total;
  logic        len_ok;
  logic        finishing;
  logic [5:0]  round;
  logic [2:0]  out_idx;
  logic [31:0] chain [sha256_pkg::CHAIN_N];
  logic [31:0] work  [sha256_pkg::CHAIN_N];
  // The block buffer doubles as the message schedule window; sched[0] is the oldest word.
  logic [31:0] sched [sha256_pkg::SCHED_N];

  logic        in_fire;
  logic        shift_en;
  logic [7:0]  shift_byte;
  logic        load_work;
  logic [63:0] len_bits;
  logic [7:0]  pad_byte;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;

  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_OUT);
  assign in_fire     = in_valid && in_ready;
  assign digest_word = chain[0];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 3'd7);

  assign len_bits = {total, 3'b000};

  always_comb begin
    // Length bytes occupy the last eight slots only once the 0x80 fits before them.
    if (len_ok && (fill[5:3] == 3'b111)) begin
      pad_byte = len_bits[{~fill[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
    shift_en   = in_fire || (state == S_PAD);
    shift_byte = pad_byte;
    if (in_fire) begin
      shift_byte = (opcode == OP_FINISH) ? sha256_pkg::PAD_BYTE : message_byte;
    end
    load_work = shift_en && (fill == 6'd63);
  end

  always_comb begin
    t1 = work[7] + sha256_pkg::big_sig1(work[4]) +
         ((work[4] & work[5]) ^ (~work[4] & work[6])) +
         sha256_pkg::k_round(round) + sched[0];
    t2 = sha256_pkg::big_sig0(work[0]) +
         ((work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]));
    w_new = sched[0] + sha256_pkg::small_sig0(sched[1]) + sched[9] +
            sha256_pkg::small_sig1(sched[14]);
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < sha256_pkg::SCHED_N - 1; i++) begin
        sched[i] <= {sched[i][23:0], sched[i+1][31:24]};
      end
      sched[sha256_pkg::SCHED_N-1] <= {sched[sha256_pkg::SCHED_N-1][23:0], shift_byte};
    end else if (state == S_COMP) begin
      for (int i = 0; i < sha256_pkg::SCHED_N - 1; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[sha256_pkg::SCHED_N-1] <= w_new;
    end

    if (load_work) begin
      for (int i = 0; i < sha256_pkg::CHAIN_N; i++) begin
        work[i] <= chain[i];
      end
    end else if (state == S_COMP) begin
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      total     <= '0;
      len_ok    <= 1'b0;
      finishing <= 1'b0;
      round     <= '0;
      out_idx   <= '0;
      for (int i = 0; i < sha256_pkg::CHAIN_N; i++) begin
        chain[i] <= sha256_pkg::h_init(3'(i));
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            fill      <= fill + 6'd1;
            finishing <= (opcode == OP_FINISH);
            if (opcode == OP_ABSORB) begin
              total <= total + 61'd1;
            end else begin
              len_ok <= (fill[5:3] != 3'b111);
            end
            if (fill == 6'd63) begin
              state <= S_COMP;
              round <= '0;
            end else if (opcode == OP_FINISH) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          fill <= fill + 6'd1;
          if (fill == 6'd63) begin
            state <= S_COMP;
            round <= '0;
          end
        end
        S_COMP: begin
          round <= round + 6'd1;
          if (round == 6'd63) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < sha256_pkg::CHAIN_N; i++) begin
            chain[i] <= chain[i] + work[i];
          end
          if (finishing && len_ok) begin
            state   <= S_OUT;
            out_idx <= '0;
          end else if (finishing) begin
            // The 0x80 filled the tail of this block; the length goes in one more block.
            len_ok <= 1'b1;
            state  <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_idx <= out_idx + 3'd1;
            for (int i = 0; i < sha256_pkg::CHAIN_N - 1; i++) begin
              chain[i] <= chain[i+1];
            end
            chain[sha256_pkg::CHAIN_N-1] <= chain[0];
            if (out_idx == 3'd7) begin
              for (int i = 0; i < sha256_pkg::CHAIN_N; i++) begin
                chain[i] <= sha256_pkg::h_init(3'(i));
              end
              total     <= '0;
              fill      <= '0;
              len_ok    <= 1'b0;
              finishing <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input accepted while a digest is pending");

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMP && round == 6'd63) |=> (state == S_ADD))
    else $error("compression did not end after the last round");

  a_new_message: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_word) |=> (in_ready && fill == 6'd0 && total == 61'd0))
    else $error("message state not cleared after the digest");

  a_comp_start: assert property (@(posedge clk) disable iff (rst)
    load_work |=> (state == S_COMP && round == 6'd0 && fill == 6'd0))
    else $error("compression started on a partial block");
`endif

endmodule
